// File: rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants for the sphere against box penetration pipeline.
// ----------------------------------------------------------------------------
package aabb_pkg;

    // register stages inside one split multiplier
    localparam int MUL_STAGES = 2;

    // number of box axes
    localparam int AXES = 3;

endpackage

// File: rtl/aabb_mul.sv
// ----------------------------------------------------------------------------
// aabb_mul
// Unsigned N x N multiplier, split into half-width partial products,
// two register stages, advanced by a shared enable.
// ----------------------------------------------------------------------------
module aabb_mul #(
    parameter int N = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [N-1:0]     i_a,
    input  logic [N-1:0]     i_b,
    output logic [2*N-1:0]   o_p
);

    localparam int K = (N + 1) / 2;
    localparam int H = N - K;

    logic [2*H-1:0]   r_hh;
    logic [H+K-1:0]   r_hl;
    logic [H+K-1:0]   r_lh;
    logic [2*K-1:0]   r_ll;
    logic [2*N-1:0]   r_p;

    // first stage: four partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= i_a[N-1:K] * i_b[N-1:K];
            r_hl <= i_a[N-1:K] * i_b[K-1:0];
            r_lh <= i_a[K-1:0] * i_b[N-1:K];
            r_ll <= i_a[K-1:0] * i_b[K-1:0];
        end
    end

    // second stage: weighted sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= ({{(2*N-2*H){1'b0}}, r_hh} << (2*K))
                 + ({{(2*N-H-K){1'b0}}, r_hl} << K)
                 + ({{(2*N-H-K){1'b0}}, r_lh} << K)
                 + {{(2*N-2*K){1'b0}}, r_ll};
        end
    end

    // two stages, matches MUL_STAGES in the package
    assign o_p = r_p;

endmodule

// File: rtl/aabb_sphere_penetration.sv
// ----------------------------------------------------------------------------
// aabb_sphere_penetration
// Sphere against axis-aligned box penetration vector, fixed point, pipelined.
// ----------------------------------------------------------------------------
// One item per clock while the output is not stalled. Each item carries a box (center, half
// extents) and a sphere (center, radius). The sphere center is clamped into
// the box, the offset is squared and summed and compared with the squared
// radius; on a hit a one-bit-per-stage square root gives the distance, and
// each offset component is scaled by (radius - distance) / distance through
// a one-bit-per-stage restoring divider, truncated toward zero. A miss, or a
// zero distance, gives a zero vector. The root and divider stage chains make up most of the
// depth from input accept to output valid; throughput is one item per cycle when the output
// is not stalled. A stall on the output freezes the whole pipeline, nothing is lost or
// repeated.
// ----------------------------------------------------------------------------
module aabb_sphere_penetration import aabb_pkg::*; #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // box_center_x/y/z, box_half_x/y/z, ball_center_x/y/z, ball_radius, zero pad
    input  logic [((10*COORD_BITS-4+7)/8)*8-1:0] i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // push_x, push_y, push_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    // hit
    output logic                  o_m_tuser
);

    localparam int W         = COORD_BITS;
    localparam int M         = W - 1;          // magnitude / root width
    localparam int OUT_BITS  = 3 * W;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
    // fraction bits cancel in every step; a negative value would force the output to all ones
    localparam int FB        = FRAC_BITS;

    typedef struct packed {
        logic                 hit;
        logic [AXES-1:0]      neg;
        logic [AXES-1:0][M-1:0] mag;
        logic [M-1:0]         rad;
    } t_side;

    // whole pipeline advances together
    logic en;
    logic r_out_v;
    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en;

    // ---------------- stage 1: box bounds ----------------
    logic                r1_v;
    logic signed [W:0]   r1_lo [AXES];
    logic signed [W:0]   r1_hi [AXES];
    logic signed [W-1:0] r1_s  [AXES];
    logic [M-1:0]        r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                r1_lo[a] <= $signed({i_s_tdata[a*W + W-1], i_s_tdata[a*W +: W]})
                          - $signed({2'b00, i_s_tdata[3*W + a*M +: M]});
                r1_hi[a] <= $signed({i_s_tdata[a*W + W-1], i_s_tdata[a*W +: W]})
                          + $signed({2'b00, i_s_tdata[3*W + a*M +: M]});
                r1_s[a]  <= i_s_tdata[6*W - 3 + a*W +: W];
            end
            r1_rad <= i_s_tdata[9*W - 3 +: M];
        end
    end

    // ---------------- stage 2: clamp and offset ----------------
    logic        r2_v;
    logic        r2_ok;
    t_side       r2_side;
    logic signed [W+1:0] off_c [AXES];
    logic signed [W:0]   clp_c [AXES];
    logic [W+1:0]        mag_c [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            clp_c[a] = ($signed({r1_s[a][W-1], r1_s[a]}) < r1_hi[a])
                     ? $signed({r1_s[a][W-1], r1_s[a]}) : r1_hi[a];
            if (clp_c[a] < r1_lo[a]) begin
                clp_c[a] = r1_lo[a];
            end
            off_c[a] = $signed({{2{r1_s[a][W-1]}}, r1_s[a]})
                     - $signed({clp_c[a][W], clp_c[a]});
            mag_c[a] = off_c[a][W+1] ? (W+2)'(-off_c[a]) : off_c[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    // magnitude at or above 2^M can never be a hit: saturate and flag it
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok <= (mag_c[0][W+1:M] == '0) && (mag_c[1][W+1:M] == '0)
                  && (mag_c[2][W+1:M] == '0);
            for (int a = 0; a < AXES; a++) begin
                r2_side.neg[a] <= off_c[a][W+1];
                r2_side.mag[a] <= (mag_c[a][W+1:M] != '0) ? {M{1'b1}} : mag_c[a][M-1:0];
            end
            r2_side.rad <= r1_rad;
            r2_side.hit <= 1'b0;
        end
    end

    // ---------------- squares ----------------
    logic [2*M-1:0] sq [AXES];
    logic [2*M-1:0] rsq;

    for (genvar a = 0; a < AXES; a++) begin : g_sq
        aabb_mul #(.N(M)) u_sq (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r2_side.mag[a]),
            .i_b   (r2_side.mag[a]),
            .o_p   (sq[a])
        );
    end

    aabb_mul #(.N(M)) u_rsq (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r2_side.rad),
        .i_b   (r2_side.rad),
        .o_p   (rsq)
    );

    logic  r_m1_v    [MUL_STAGES];
    logic  r_m1_ok   [MUL_STAGES];
    t_side r_m1_side [MUL_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MUL_STAGES; k++) begin
                r_m1_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_m1_v[0] <= r2_v;
            for (int k = 1; k < MUL_STAGES; k++) begin
                r_m1_v[k] <= r_m1_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_ok[0]   <= r2_ok;
            r_m1_side[0] <= r2_side;
            for (int k = 1; k < MUL_STAGES; k++) begin
                r_m1_ok[k]   <= r_m1_ok[k-1];
                r_m1_side[k] <= r_m1_side[k-1];
            end
        end
    end

    // ---------------- stage: sum of squares ----------------
    logic           r5_v;
    logic           r5_ok;
    t_side          r5_side;
    logic [2*M+1:0] r5_dsq;
    logic [2*M-1:0] r5_rsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r_m1_v[MUL_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dsq  <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
            r5_rsq  <= rsq;
            r5_ok   <= r_m1_ok[MUL_STAGES-1];
            r5_side <= r_m1_side[MUL_STAGES-1];
        end
    end

    // ---------------- stage: compare ----------------
    logic           r6_v;
    t_side          r6_side;
    t_side          n6_side;
    logic [2*M-1:0] r6_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_comb begin
        n6_side     = r5_side;
        n6_side.hit = r5_ok && (r5_dsq < {2'b00, r5_rsq});
    end

    // on a hit the squared sum is below 2^(2M), so the low bits are exact
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= n6_side;
            r6_n    <= r5_dsq[2*M-1:0];
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic           r_sq_v    [M];
    logic [M+1:0]   r_sq_rem  [M];
    logic [M-1:0]   r_sq_root [M];
    logic [2*M-1:0] r_sq_n    [M];
    t_side          r_sq_side [M];

    for (genvar j = 0; j < M; j++) begin : g_root
        logic [M+1:0]   rem_in;
        logic [M-1:0]   root_in;
        logic [2*M-1:0] n_in;
        logic [M+1:0]   rem_t;
        logic [M+1:0]   trial;
        logic           v_in;
        t_side          side_in;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = r6_n;
            assign v_in    = r6_v;
            assign side_in = r6_side;
        end else begin : g_next
            assign rem_in  = r_sq_rem[j-1];
            assign root_in = r_sq_root[j-1];
            assign n_in    = r_sq_n[j-1];
            assign v_in    = r_sq_v[j-1];
            assign side_in = r_sq_side[j-1];
        end

        assign rem_t = {rem_in[M-1:0], n_in[2*(M-1-j) +: 2]};
        // 4*root + 1
        assign trial = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (en) begin
                r_sq_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_n[j]    <= n_in;
                r_sq_side[j] <= side_in;
                if (rem_t >= trial) begin
                    r_sq_rem[j]  <= rem_t - trial;
                    r_sq_root[j] <= {root_in[M-2:0], 1'b1};
                end else begin
                    r_sq_rem[j]  <= rem_t;
                    r_sq_root[j] <= {root_in[M-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- stage: penetration depth ----------------
    logic         r7_v;
    logic         r7_zero;
    t_side        r7_side;
    logic [M-1:0] r7_dist;
    logic [M-1:0] r7_pen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r_sq_v[M-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side <= r_sq_side[M-1];
            r7_dist <= r_sq_root[M-1];
            r7_pen  <= r_sq_side[M-1].rad - r_sq_root[M-1];
            r7_zero <= (r_sq_root[M-1] == '0);
        end
    end

    // ---------------- offset times depth ----------------
    logic [2*M-1:0] prod [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_prod
        aabb_mul #(.N(M)) u_prod (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r7_side.mag[a]),
            .i_b   (r7_pen),
            .o_p   (prod[a])
        );
    end

    logic         r_m2_v    [MUL_STAGES];
    logic         r_m2_keep [MUL_STAGES];
    logic [AXES-1:0] r_m2_neg [MUL_STAGES];
    logic         r_m2_hit  [MUL_STAGES];
    logic [M-1:0] r_m2_dist [MUL_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MUL_STAGES; k++) begin
                r_m2_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_m2_v[0] <= r7_v;
            for (int k = 1; k < MUL_STAGES; k++) begin
                r_m2_v[k] <= r_m2_v[k-1];
            end
        end
    end

    // keep: nonzero push allowed (hit with nonzero distance)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_keep[0] <= r7_side.hit && !r7_zero;
            r_m2_neg[0]  <= r7_side.neg;
            r_m2_hit[0]  <= r7_side.hit;
            r_m2_dist[0] <= r7_dist;
            for (int k = 1; k < MUL_STAGES; k++) begin
                r_m2_keep[k] <= r_m2_keep[k-1];
                r_m2_neg[k]  <= r_m2_neg[k-1];
                r_m2_hit[k]  <= r_m2_hit[k-1];
                r_m2_dist[k] <= r_m2_dist[k-1];
            end
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    // on a kept item the quotient is below 2^M, so the high half of the
    // dividend starts as the partial remainder
    logic            r_dv_v    [M];
    logic            r_dv_keep [M];
    logic            r_dv_hit  [M];
    logic [AXES-1:0] r_dv_neg  [M];
    logic [M-1:0]    r_dv_d    [M];
    logic [M:0]      r_dv_r    [M][AXES];
    logic [M-1:0]    r_dv_q    [M][AXES];
    logic [M-1:0]    r_dv_lo   [M][AXES];

    for (genvar j = 0; j < M; j++) begin : g_div
        logic            v_in;
        logic            keep_in;
        logic            hit_in;
        logic [AXES-1:0] neg_in;
        logic [M-1:0]    d_in;
        logic [M:0]      r_in  [AXES];
        logic [M-1:0]    q_in  [AXES];
        logic [M-1:0]    lo_in [AXES];
        logic [M:0]      r_t   [AXES];

        if (j == 0) begin : g_first
            assign v_in    = r_m2_v[MUL_STAGES-1];
            assign keep_in = r_m2_keep[MUL_STAGES-1];
            assign hit_in  = r_m2_hit[MUL_STAGES-1];
            assign neg_in  = r_m2_neg[MUL_STAGES-1];
            assign d_in    = r_m2_dist[MUL_STAGES-1];
            for (genvar a = 0; a < AXES; a++) begin : g_ax
                assign r_in[a]  = {1'b0, prod[a][2*M-1:M]};
                assign q_in[a]  = '0;
                assign lo_in[a] = prod[a][M-1:0];
            end
        end else begin : g_next
            assign v_in    = r_dv_v[j-1];
            assign keep_in = r_dv_keep[j-1];
            assign hit_in  = r_dv_hit[j-1];
            assign neg_in  = r_dv_neg[j-1];
            assign d_in    = r_dv_d[j-1];
            for (genvar a = 0; a < AXES; a++) begin : g_ax
                assign r_in[a]  = r_dv_r[j-1][a];
                assign q_in[a]  = r_dv_q[j-1][a];
                assign lo_in[a] = r_dv_lo[j-1][a];
            end
        end

        always_comb begin
            for (int a = 0; a < AXES; a++) begin
                r_t[a] = {r_in[a][M-1:0], lo_in[a][M-1-j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_keep[j] <= keep_in;
                r_dv_hit[j]  <= hit_in;
                r_dv_neg[j]  <= neg_in;
                r_dv_d[j]    <= d_in;
                for (int a = 0; a < AXES; a++) begin
                    r_dv_lo[j][a] <= lo_in[a];
                    if (r_t[a] >= {1'b0, d_in}) begin
                        r_dv_r[j][a] <= r_t[a] - {1'b0, d_in};
                        r_dv_q[j][a] <= {q_in[a][M-2:0], 1'b1};
                    end else begin
                        r_dv_r[j][a] <= r_t[a];
                        r_dv_q[j][a] <= {q_in[a][M-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- output register ----------------
    // quotient never exceeds the radius, so the signed result always fits
    logic [W-1:0] r_push [AXES];
    logic         r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[M-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= r_dv_hit[M-1];
            for (int a = 0; a < AXES; a++) begin
                if (!r_dv_keep[M-1]) begin
                    r_push[a] <= '0;
                end else if (r_dv_neg[M-1][a]) begin
                    r_push[a] <= W'(-{1'b0, r_dv_q[M-1][a]});
                end else begin
                    r_push[a] <= {1'b0, r_dv_q[M-1][a]};
                end
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_hit;
    assign o_m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, r_push[2], r_push[1], r_push[0]}
                      | {(OUT_BYTES*8){FB < 0}};

endmodule
